// ===== sv/c2d_pkg.sv =====
package c2d_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 12;
    localparam int TAPS        = 9;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W       = 11;
    localparam int LINE_W      = 2 * SAMPLE_BITS;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int PART_W      = PROD_W + 2;
    localparam int RESULT_W    = 32;
    localparam int FIRST_W     = 5 * COEF_BITS;
    localparam int LAST_W      = 4 * COEF_BITS;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = FIRST_W;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_COEFFS_FIRST = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_COEFFS_LAST  = CFG_INDEX_W'(3);

    // center tap at 1.0 in Q4.8, all others zero
    localparam logic [FIRST_W-1:0] COEFFS_FIRST_RESET = FIRST_W'(64'h0100_0000_0000_0000);
    localparam logic [LAST_W-1:0]  COEFFS_LAST_RESET  = '0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel;
        logic                          flush;
    } c2d_in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] filtered;
        logic                       last_of_frame;
    } c2d_out_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [LINE_W-1:0] data;
    } c2d_ram_wr_t;

endpackage

// ===== sv/conv2d_3x3_same_zero_pad_top.sv =====
// 3x3 same-size convolution with zero padding over a raster-order stream.
// in channel (in_valid/in_ready/in_word): one word per pixel, row by row;
// flush words count as zero pixels and are sent image_width+1 times after
// the last pixel of a frame to push out the pending results.
// out channel (out_valid/out_ready/out_word): one result per pixel, the sum
// of nine signed Q4.8 products, with last_of_frame on the bottom-right one.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 width, 1 height (both restart the frame position), 2 and 3 taps.
// Write it only while the stream is idle.
// The result for pixel p passes stages a to d and the output register after
// the word of position p+image_width+1 is accepted. One word is taken every
// cycle: both line stores live in one read-modify-write memory read at
// accept and written back as the word leaves stage a, with a forward when
// the same column repeats. The multiply and add pipeline fills its own gaps,
// so input keeps flowing while a result waits for out_ready, until the
// pipeline is full. Reset clears window, position and pipeline and loads
// the identity kernel and 1024x1024 frame; line memory needs no clearing.
module conv2d_3x3_same_zero_pad_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  c2d_pkg::c2d_in_t                  in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output c2d_pkg::c2d_out_t                 out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [c2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int S  = c2d_pkg::SAMPLE_BITS;
    localparam int DW = c2d_pkg::DIM_W;
    localparam int AW = c2d_pkg::ADDR_W;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } c2d_edge_t;

    function automatic logic [DW-1:0] clamp_dim(input logic [c2d_pkg::CFG_DATA_W-1:0] v,
                                                input logic [DW-1:0] maxv);
        logic [DW-1:0] t;
        t = v[DW-1:0];
        if (t == '0)
        begin
            t = DW'(1);
        end
        if (t > maxv)
        begin
            t = maxv;
        end
        return t;
    endfunction

    // configuration
    logic [DW-1:0]                  img_width_reg;
    logic [DW-1:0]                  img_height_reg;
    logic [c2d_pkg::FIRST_W-1:0]    coef_first_reg;
    logic [c2d_pkg::LAST_W-1:0]     coef_last_reg;
    logic                           cfg_fire;
    logic                           cfg_restart;

    // position and accept
    logic [AW-1:0]   ic_reg;
    logic [DW-1:0]   ir_reg;
    logic            in_fire;
    logic            at_col0;
    logic            produce;
    logic [DW-1:0]   orow;
    logic [DW-1:0]   ocol;
    logic [DW-1:0]   ic_plus;
    c2d_edge_t       edge_in;
    logic [S-1:0]    sample_in;

    // stage a: line data arrives, window update
    logic            a_valid_reg;
    logic [S-1:0]    a_sample_reg;
    logic [AW-1:0]   a_addr_reg;
    logic            a_produce_reg;
    logic            a_pre_reg;
    c2d_edge_t       a_edge_reg;
    logic            a_move;
    logic [c2d_pkg::LINE_W-1:0] line_q;
    logic [S-1:0]    new_col [3];
    logic [S-1:0]    sel [c2d_pkg::TAPS];
    c2d_pkg::c2d_ram_wr_t ram_wr;

    // window, [column oldest..newest][row top..bottom]
    logic [S-1:0]    win_reg [3][3];

    // stage b: masked samples
    logic                     b_valid_reg;
    logic signed [S-1:0]      b_samp_reg [c2d_pkg::TAPS];
    logic                     b_last_reg;
    // stage c: products
    logic                                  c_valid_reg;
    logic signed [c2d_pkg::PROD_W-1:0]     c_prod_reg [c2d_pkg::TAPS];
    logic                                  c_last_reg;
    // stage d: row sums
    logic                                  d_valid_reg;
    logic signed [c2d_pkg::PART_W-1:0]     d_part_reg [3];
    logic                                  d_last_reg;
    // output
    logic                 out_valid_reg;
    c2d_pkg::c2d_out_t    out_word_reg;

    logic ld_o, ld_d, ld_c, ld_b;
    logic signed [c2d_pkg::COEF_BITS-1:0] tap [c2d_pkg::TAPS];
    logic signed [c2d_pkg::RESULT_W-1:0]  sum_all;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_fire && ((cfg_index == c2d_pkg::REG_IMAGE_WIDTH) ||
                                      (cfg_index == c2d_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= DW'(c2d_pkg::MAX_WIDTH);
            img_height_reg <= DW'(c2d_pkg::MAX_HEIGHT);
            coef_first_reg <= c2d_pkg::COEFFS_FIRST_RESET;
            coef_last_reg  <= c2d_pkg::COEFFS_LAST_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                c2d_pkg::REG_IMAGE_WIDTH:
                    img_width_reg <= clamp_dim(cfg_data, DW'(c2d_pkg::MAX_WIDTH));
                c2d_pkg::REG_IMAGE_HEIGHT:
                    img_height_reg <= clamp_dim(cfg_data, DW'(c2d_pkg::MAX_HEIGHT));
                c2d_pkg::REG_COEFFS_FIRST:
                    coef_first_reg <= cfg_data[c2d_pkg::FIRST_W-1:0];
                c2d_pkg::REG_COEFFS_LAST:
                    coef_last_reg <= cfg_data[c2d_pkg::LAST_W-1:0];
                default:
                    coef_last_reg <= coef_last_reg;
            endcase
        end
    end

    // handshake through the pipeline, bubbles get filled
    assign ld_o     = !out_valid_reg || out_ready;
    assign ld_d     = !d_valid_reg || ld_o;
    assign ld_c     = !c_valid_reg || ld_d;
    assign ld_b     = !b_valid_reg || ld_c;
    assign a_move   = a_valid_reg && (!a_produce_reg || ld_b);
    assign in_ready = !a_valid_reg || a_move;
    assign in_fire  = in_valid && in_ready;

    // where the result leaving with this word sits in the image
    always_comb
    begin
        sample_in = in_word.flush ? '0 : in_word.pixel;
        at_col0   = (ic_reg == '0);
        produce   = (ir_reg >= DW'(2)) || ((ir_reg == DW'(1)) && !at_col0);
        orow      = at_col0 ? (ir_reg - DW'(2)) : (ir_reg - DW'(1));
        ocol      = at_col0 ? (img_width_reg - DW'(1)) : (DW'(ic_reg) - DW'(1));
        ic_plus   = DW'(ic_reg) + DW'(1);
        edge_in.top_ok   = (orow != '0);
        edge_in.bot_ok   = (orow != (img_height_reg - DW'(1)));
        edge_in.left_ok  = (ocol != '0);
        edge_in.right_ok = !at_col0 && (ocol != (img_width_reg - DW'(1)));
        edge_in.last     = (orow == (img_height_reg - DW'(1))) &&
                           (ocol == (img_width_reg - DW'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg <= '0;
            ir_reg <= '0;
        end
        else if (cfg_restart)
        begin
            ic_reg <= '0;
            ir_reg <= '0;
        end
        else if (in_fire)
        begin
            if (produce && edge_in.last)
            begin
                ic_reg <= '0;
                ir_reg <= '0;
            end
            else if (ic_plus >= img_width_reg)
            begin
                ic_reg <= '0;
                ir_reg <= ir_reg + DW'(1);
            end
            else
            begin
                ic_reg <= ic_plus[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_sample_reg  <= sample_in;
            a_addr_reg    <= ic_reg;
            a_produce_reg <= produce;
            a_pre_reg     <= at_col0;
            a_edge_reg    <= edge_in;
        end
    end

    assign ram_wr.en   = a_move;
    assign ram_wr.addr = a_addr_reg;
    assign ram_wr.data = {line_q[S-1:0], a_sample_reg};

    c2d_line_ram u_line_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (ic_reg),
        .wr      (ram_wr),
        .rd_data (line_q)
    );

    // at column 0 the result is the last pixel of the row two rows up, taken
    // from the window before this word shifts in
    always_comb
    begin
        new_col[0] = line_q[c2d_pkg::LINE_W-1:S];
        new_col[1] = line_q[S-1:0];
        new_col[2] = a_sample_reg;
        for (int r = 0; r < 3; r++)
        begin
            sel[3*r]     = (a_edge_reg.left_ok && (r != 0 || a_edge_reg.top_ok) &&
                            (r != 2 || a_edge_reg.bot_ok)) ? win_reg[1][r] : '0;
            sel[3*r + 1] = ((r != 0 || a_edge_reg.top_ok) &&
                            (r != 2 || a_edge_reg.bot_ok)) ? win_reg[2][r] : '0;
            sel[3*r + 2] = (!a_pre_reg && a_edge_reg.right_ok &&
                            (r != 0 || a_edge_reg.top_ok) &&
                            (r != 2 || a_edge_reg.bot_ok)) ? new_col[r] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[c][r] <= '0;
                end
            end
        end
        else if (a_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= win_reg[2][r];
                win_reg[2][r] <= new_col[r];
            end
        end
    end

    // taps row-major; the kernel is applied rotated
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            tap[k] = coef_first_reg[c2d_pkg::COEF_BITS*k +: c2d_pkg::COEF_BITS];
        end
        for (int k = 5; k < c2d_pkg::TAPS; k++)
        begin
            tap[k] = coef_last_reg[c2d_pkg::COEF_BITS*(k-5) +: c2d_pkg::COEF_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_b)
            begin
                b_valid_reg <= a_valid_reg && a_produce_reg;
            end
            if (ld_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (ld_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (ld_o)
            begin
                out_valid_reg <= d_valid_reg;
            end
        end
    end

    assign sum_all = c2d_pkg::RESULT_W'(d_part_reg[0]) + c2d_pkg::RESULT_W'(d_part_reg[1]) +
                     c2d_pkg::RESULT_W'(d_part_reg[2]);

    always_ff @(posedge clk)
    begin
        if (ld_b && a_valid_reg && a_produce_reg)
        begin
            for (int k = 0; k < c2d_pkg::TAPS; k++)
            begin
                b_samp_reg[k] <= sel[k];
            end
            b_last_reg <= a_edge_reg.last;
        end
        if (ld_c && b_valid_reg)
        begin
            for (int k = 0; k < c2d_pkg::TAPS; k++)
            begin
                c_prod_reg[k] <= c2d_pkg::PROD_W'(b_samp_reg[k]) *
                                 c2d_pkg::PROD_W'(tap[c2d_pkg::TAPS-1-k]);
            end
            c_last_reg <= b_last_reg;
        end
        if (ld_d && c_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                d_part_reg[r] <= c2d_pkg::PART_W'(c_prod_reg[3*r]) +
                                 c2d_pkg::PART_W'(c_prod_reg[3*r + 1]) +
                                 c2d_pkg::PART_W'(c_prod_reg[3*r + 2]);
            end
            d_last_reg <= c_last_reg;
        end
        if (ld_o && d_valid_reg)
        begin
            out_word_reg.filtered      <= sum_all;
            out_word_reg.last_of_frame <= d_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        DW'(ic_reg) < img_width_reg)
        else $error("column position beyond image width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (DW+1)'(ir_reg) <= ((DW+1)'(img_height_reg) + (DW+1)'(1)))
        else $error("row position beyond frame plus flush row");

    a_dim_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> (ic_reg == '0) && (ir_reg == '0))
        else $error("frame position not restarted after size write");

    a_result_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_produce_reg && ld_b) |=> b_valid_reg)
        else $error("result word lost between window and multiply stage");
`endif

endmodule

// ===== sv/c2d_line_ram.sv =====
module c2d_line_ram (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [c2d_pkg::ADDR_W-1:0] rd_addr,
    input  c2d_pkg::c2d_ram_wr_t      wr,
    output logic [c2d_pkg::LINE_W-1:0] rd_data
);

    logic [c2d_pkg::LINE_W-1:0] mem [c2d_pkg::MAX_WIDTH];
    logic [c2d_pkg::LINE_W-1:0] q_reg;
    logic [c2d_pkg::LINE_W-1:0] fwd_data_reg;
    logic                       fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    // read and write of the same entry at one edge: hand over the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule
